// ===== design/ops_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Orbit position stepper package
// Shared types, constants and the half-wave sine table for the stepper.
// ----------------------------------------------------------------------------
package ops_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORBIT_KIND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FRAC = 2'd1;

  // Orbit set constants
  localparam logic [7:0] ANGLE_STEP_INNER = 8'h70;
  localparam logic [7:0] ANGLE_STEP_OUTER = 8'h60;
  localparam logic [7:0] RADIUS_INNER     = 8'h2C;
  localparam logic [7:0] RADIUS_OUTER     = 8'h18;
  localparam logic [4:0] PLACE_ANGLE      = 5'h18;
  localparam logic [4:0] QUARTER_TURN     = 5'd8;

  typedef enum logic {
    CMD_PLACE = 1'b0,
    CMD_STEP  = 1'b1
  } ops_cmd_t;

  // One input item
  typedef struct packed {
    ops_cmd_t   cmd;
    logic [7:0] parent_x;
    logic [7:0] parent_y;
    logic [7:0] offset_x;
    logic [7:0] offset_y;
    logic       maneuver;
  } ops_item_t;

  // Position and angle state
  typedef struct packed {
    logic [7:0] x_whole;
    logic [7:0] x_frac;
    logic [7:0] y_whole;
    logic [7:0] y_frac;
    logic [4:0] angle_int;
    logic [7:0] angle_frac;
  } ops_state_t;

  // Sixteen-entry sine table, one half turn
  function automatic logic [7:0] ops_sine(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h00;
      4'd1:    val = 8'h18;
      4'd2:    val = 8'h30;
      4'd3:    val = 8'h47;
      4'd4:    val = 8'h5A;
      4'd5:    val = 8'h6A;
      4'd6:    val = 8'h76;
      4'd7:    val = 8'h7D;
      4'd8:    val = 8'h80;
      4'd9:    val = 8'h7D;
      4'd10:   val = 8'h76;
      4'd11:   val = 8'h6A;
      4'd12:   val = 8'h5A;
      4'd13:   val = 8'h47;
      4'd14:   val = 8'h30;
      4'd15:   val = 8'h18;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== design/ops_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Orbit stepper datapath
// Computes the next position and angle state from the current state and one
// place or step item.
// ----------------------------------------------------------------------------
module ops_datapath (
  input  wire ops_pkg::ops_state_t state_i,
  input  wire ops_pkg::ops_item_t  item_i,
  input  wire logic                orbit_kind,
  input  wire logic [7:0]          speed_frac,
  output ops_pkg::ops_state_t      state_o
);
  import ops_pkg::*;

  logic [12:0] angle_new;
  logic [4:0]  ang;
  logic [4:0]  ang_back;
  logic [7:0]  sin_x;
  logic [7:0]  sin_y;
  logic        x_six;
  logic        y_six;
  logic [5:0]  mul_x;
  logic [5:0]  mul_y;
  logic [13:0] delta_x;
  logic [13:0] delta_y;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] next_x;
  logic [15:0] next_y;

  // Turn the angle; the borrow out of the fraction comes off the whole part
  assign angle_new = {state_i.angle_int, state_i.angle_frac}
                   - {5'd0, (orbit_kind ? ANGLE_STEP_OUTER : ANGLE_STEP_INNER)};
  assign ang       = angle_new[12:8];
  assign ang_back  = ang - QUARTER_TURN;

  // Look up sine for X and cosine (quarter turn ahead) for Y
  assign sin_x = ops_sine(ang[3:0]);
  assign sin_y = ops_sine({~ang[3], ang[2:0]});

  // Pick multiplier bit counts per orbit set and maneuver
  assign x_six = orbit_kind ? item_i.maneuver : 1'b1;
  assign y_six = orbit_kind ? item_i.maneuver : ~item_i.maneuver;
  assign mul_x = x_six ? sin_x[7:2] : {1'b0, sin_x[7:3]};
  assign mul_y = y_six ? sin_y[7:2] : {1'b0, sin_y[7:3]};

  assign delta_x = {6'd0, speed_frac} * {8'd0, mul_x};
  assign delta_y = {6'd0, speed_frac} * {8'd0, mul_y};

  // Follow the parent's travel, then move along the orbit
  assign pos_x  = {state_i.x_whole + item_i.offset_x, state_i.x_frac};
  assign pos_y  = {state_i.y_whole + item_i.offset_y, state_i.y_frac};
  assign next_x = ang[4] ? pos_x - {2'd0, delta_x} : pos_x + {2'd0, delta_x};
  assign next_y = ang_back[4] ? pos_y - {2'd0, delta_y} : pos_y + {2'd0, delta_y};

  // Select place or step result
  always_comb begin
    state_o = state_i;
    if (item_i.cmd == CMD_PLACE) begin
      state_o.x_whole   = item_i.parent_x;
      state_o.y_whole   = item_i.parent_y - (orbit_kind ? RADIUS_OUTER : RADIUS_INNER);
      state_o.angle_int = PLACE_ANGLE;
    end else begin
      state_o.x_whole    = next_x[15:8];
      state_o.x_frac     = next_x[7:0];
      state_o.y_whole    = next_y[15:8];
      state_o.y_frac     = next_y[7:0];
      state_o.angle_int  = ang;
      state_o.angle_frac = angle_new[7:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/orbit_position_stepper_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Orbit position stepper
// Places an orbiting object relative to its parent and steps it around the
// orbit, one result per item.
// ----------------------------------------------------------------------------
// Each item is held in the input register and then moves into the state
// register, which is also the result register. out_valid rises when the item
// reaches the state register. A new item is taken every cycle while the
// result channel is not stalled; the sustained rate is then one item per
// clock, set by the combinational update of the position and angle state.
// With the result channel stalled the unit holds one further item in its
// input register. Configuration writes are always taken (cfg_ready is tied
// high); indexes beyond the two registers are ignored.
module orbit_position_stepper_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_cmd,
  input  wire logic [7:0]                    in_parent_x,
  input  wire logic [7:0]                    in_parent_y,
  input  wire logic [7:0]                    in_offset_x,
  input  wire logic [7:0]                    in_offset_y,
  input  wire logic                          in_maneuver,
  // result channel
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [7:0]                    out_pos_x,
  output      logic [7:0]                    out_pos_y,
  output      logic [4:0]                    out_angle_whole,
  // configuration
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [ops_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data
);
  import ops_pkg::*;

  logic       orbit_kind_r;
  logic [7:0] speed_frac_r;
  logic       in_valid_r;
  ops_item_t  item_r;
  ops_item_t  item_in;
  ops_state_t state_r;
  ops_state_t state_nxt;
  logic       out_valid_r;
  logic       advance;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orbit_kind_r <= 1'b0;
      speed_frac_r <= 8'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ORBIT_KIND) begin
        orbit_kind_r <= cfg_data[0];
      end else if (cfg_index == CFG_SPEED_FRAC) begin
        speed_frac_r <= cfg_data;
      end
    end
  end

  // Advance the held item when the result register is free or being taken
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  assign item_in.cmd      = ops_cmd_t'(in_cmd);
  assign item_in.parent_x = in_parent_x;
  assign item_in.parent_y = in_parent_y;
  assign item_in.offset_x = in_offset_x;
  assign item_in.offset_y = in_offset_y;
  assign item_in.maneuver = in_maneuver;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_in;
    end
  end

  ops_datapath u_datapath (
    .state_i    (state_r),
    .item_i     (item_r),
    .orbit_kind (orbit_kind_r),
    .speed_frac (speed_frac_r),
    .state_o    (state_nxt)
  );

  // State register doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = state_r.x_whole;
  assign out_pos_y       = state_r.y_whole;
  assign out_angle_whole = state_r.angle_int;

endmodule
`default_nettype wire

// ===== design/ops_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Orbit stepper port checker
// Watches the top-level ports for reset, stall and latency behaviour.
// ----------------------------------------------------------------------------
module ops_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_pos_x,
  input wire logic [7:0] out_pos_y,
  input wire logic [4:0] out_angle_whole,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pos_x)
      && $stable(out_pos_y) && $stable(out_angle_whole)))
    else $error("stalled result changed");

  // A result into an empty output stems from an input transfer that passed
  // through the input register into the state register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input transfer");

  // Configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind orbit_position_stepper_unit ops_checker u_ops_checker (.*);
`default_nettype wire
